### rtl/assert_macros.svh
// Assertion macros used by the RTL modules (uvdi_recip includes them).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/uvdi_pkg.sv
// Package: constants and types of the vector divide-by-invariant unit.
`default_nettype none
package uvdi_pkg;

  localparam int unsigned LANES     = 4;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned SHIFT_W   = $clog2(WORD_BITS);

  typedef logic [WORD_BITS-1:0] word_t;

  // Precomputed reciprocal and shift amounts for the current divisor.
  typedef struct packed {
    word_t              mult;
    logic               shift1;
    logic [SHIFT_W-1:0] shift2;
  } coef_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOG,
    ST_DIV
  } recip_state_e;

endpackage
`default_nettype wire

### rtl/uvdi_intf.sv
// Handshake channel interfaces: dividends in, quotients out, divisor writes.
`default_nettype none
interface uvdi_div_if;
  logic                  valid;
  logic                  ready;
  logic [uvdi_pkg::WORD_BITS-1:0] dividend_0;
  logic [uvdi_pkg::WORD_BITS-1:0] dividend_1;
  logic [uvdi_pkg::WORD_BITS-1:0] dividend_2;
  logic [uvdi_pkg::WORD_BITS-1:0] dividend_3;
  modport source (output valid, dividend_0, dividend_1, dividend_2, dividend_3,
                  input ready);
  modport sink   (input valid, dividend_0, dividend_1, dividend_2, dividend_3,
                  output ready);
endinterface

interface uvdi_quo_if;
  logic                  valid;
  logic                  ready;
  logic [uvdi_pkg::WORD_BITS-1:0] quotient_0;
  logic [uvdi_pkg::WORD_BITS-1:0] quotient_1;
  logic [uvdi_pkg::WORD_BITS-1:0] quotient_2;
  logic [uvdi_pkg::WORD_BITS-1:0] quotient_3;
  modport source (output valid, quotient_0, quotient_1, quotient_2, quotient_3,
                  input ready);
  modport sink   (input valid, quotient_0, quotient_1, quotient_2, quotient_3,
                  output ready);
endinterface

interface uvdi_cfg_if;
  logic                  valid;
  logic                  ready;
  logic [uvdi_pkg::WORD_BITS-1:0] divisor;
  modport source (output valid, divisor, input ready);
  modport sink   (input valid, divisor, output ready);
endinterface
`default_nettype wire

### rtl/uvdi_recip.sv
// Reciprocal sequencer: log2 search and bit-serial long division on divisor write.
`default_nettype none
`include "assert_macros.svh"
module uvdi_recip (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           wr_valid_i,
  output logic                                wr_ready_o,
  input  wire logic [uvdi_pkg::WORD_BITS-1:0] wr_data_i,
  output logic                                busy_o,
  output uvdi_pkg::coef_t                     coef_o
);

  localparam int unsigned W  = uvdi_pkg::WORD_BITS;
  localparam int unsigned SW = uvdi_pkg::SHIFT_W;

  uvdi_pkg::recip_state_e state_q, state_d;
  uvdi_pkg::coef_t        coef_q;

  logic [W:0]    dd_q;    // divisor, zero taken as 2^W
  logic [W:0]    pow_q;   // 2^lg
  logic [SW:0]   lg_q;
  logic [W:0]    rem_q;
  logic [W-1:0]  quo_q;
  logic [SW-1:0] cnt_q;

  logic          log_more;
  logic          div_last;
  logic [W+1:0]  rem_sh;
  logic [W+1:0]  rem_sub;
  logic          rem_ge;
  logic [W-1:0]  quo_nxt;
  logic [SW:0]   lg_dec;

  // controls from the output decode
  logic start, log_step, log_done, div_step, div_done;

  assign log_more = (lg_q < (SW+1)'(W)) && (pow_q < dd_q);
  assign div_last = (cnt_q == SW'(W - 1));
  assign rem_sh   = {rem_q, 1'b0};
  assign rem_sub  = rem_sh - {1'b0, dd_q};
  assign rem_ge   = (rem_sh >= {1'b0, dd_q});
  assign quo_nxt  = {quo_q[W-2:0], rem_ge};
  assign lg_dec   = lg_q - (SW+1)'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      uvdi_pkg::ST_IDLE: if (wr_valid_i) state_d = uvdi_pkg::ST_LOG;
      uvdi_pkg::ST_LOG:  if (!log_more) state_d = uvdi_pkg::ST_DIV;
      uvdi_pkg::ST_DIV:  if (div_last) state_d = uvdi_pkg::ST_IDLE;
      default:           state_d = uvdi_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    start      = 1'b0;
    log_step   = 1'b0;
    log_done   = 1'b0;
    div_step   = 1'b0;
    div_done   = 1'b0;
    wr_ready_o = 1'b0;
    busy_o     = 1'b1;
    unique case (state_q)
      uvdi_pkg::ST_IDLE: begin
        wr_ready_o = 1'b1;
        busy_o     = 1'b0;
        start      = wr_valid_i;
      end
      uvdi_pkg::ST_LOG: begin
        log_step = log_more;
        log_done = !log_more;
      end
      uvdi_pkg::ST_DIV: begin
        div_step = 1'b1;
        div_done = div_last;
      end
      default: busy_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= uvdi_pkg::ST_IDLE;
      coef_q.mult   <= W'(1);
      coef_q.shift1 <= 1'b0;
      coef_q.shift2 <= '0;
    end else begin
      state_q <= state_d;
      if (div_done) begin
        coef_q.mult   <= quo_nxt + W'(1);
        coef_q.shift1 <= (lg_q != '0);
        coef_q.shift2 <= (lg_q != '0) ? lg_dec[SW-1:0] : '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      dd_q  <= (wr_data_i == '0) ? {1'b1, W'(0)} : {1'b0, wr_data_i};
      pow_q <= (W+1)'(1);
      lg_q  <= '0;
    end
    if (log_step) begin
      pow_q <= {pow_q[W-1:0], 1'b0};
      lg_q  <= lg_q + (SW+1)'(1);
    end
    if (log_done) begin
      rem_q <= pow_q - dd_q;
      quo_q <= '0;
      cnt_q <= '0;
    end
    if (div_step) begin
      rem_q <= rem_ge ? rem_sub[W:0] : rem_sh[W:0];
      quo_q <= quo_nxt;
      cnt_q <= cnt_q + SW'(1);
    end
  end

  assign coef_o = coef_q;

  `ASSERT_NEXT(a_write_starts, clk_i, rst_ni, wr_valid_i && wr_ready_o,
               state_q == uvdi_pkg::ST_LOG, "divisor write did not start search")
  `ASSERT_IMPLIES(a_pow_onehot, clk_i, rst_ni, state_q == uvdi_pkg::ST_LOG,
                  $onehot(pow_q), "power register lost one-hot form")
  `ASSERT_IMPLIES(a_rem_below, clk_i, rst_ni, state_q == uvdi_pkg::ST_DIV,
                  rem_q < dd_q, "partial remainder not below divisor")

endmodule
`default_nettype wire

### rtl/uvdi_pipe.sv
// Four-stage lane datapath: multiply-high, subtract and shift, add, final shift.
`default_nettype none
module uvdi_pipe (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire uvdi_pkg::coef_t                coef_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire uvdi_pkg::word_t                in_data_i [uvdi_pkg::LANES],
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output uvdi_pkg::word_t                     out_data_o [uvdi_pkg::LANES]
);

  localparam int unsigned W = uvdi_pkg::WORD_BITS;
  localparam int unsigned N = uvdi_pkg::LANES;

  logic v1_q, v2_q, v3_q, v4_q;
  logic r1, r2, r3, r4;

  logic [2*W-1:0]   prod [N];
  uvdi_pkg::word_t  x1_q [N];
  uvdi_pkg::word_t  t1_q [N];
  uvdi_pkg::word_t  t2_q [N];
  uvdi_pkg::word_t  d2_q [N];
  uvdi_pkg::word_t  s3_q [N];
  uvdi_pkg::word_t  q4_q [N];
  uvdi_pkg::word_t  diff [N];

  // a stage takes new data when empty or when its successor takes its item
  assign r4 = !v4_q || out_ready_i;
  assign r3 = !v3_q || r4;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign in_ready_o = r1;

  always_comb begin
    for (int l = 0; l < N; l++) begin
      prod[l] = (2*W)'(in_data_i[l]) * (2*W)'(coef_i.mult);
      diff[l] = x1_q[l] - t1_q[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (r1) v1_q <= in_valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < N; l++) begin
      if (r1 && in_valid_i) begin
        x1_q[l] <= in_data_i[l];
        t1_q[l] <= prod[l][2*W-1:W];
      end
      if (r2 && v1_q) begin
        t2_q[l] <= t1_q[l];
        d2_q[l] <= diff[l] >> coef_i.shift1;
      end
      if (r3 && v2_q) begin
        s3_q[l] <= t2_q[l] + d2_q[l];
      end
      if (r4 && v3_q) begin
        q4_q[l] <= s3_q[l] >> coef_i.shift2;
      end
    end
  end

  assign out_valid_o = v4_q;
  assign out_data_o  = q4_q;

endmodule
`default_nettype wire

### rtl/unsigned32_vector_divide_by_invariant_unit.sv
// Items pass the multiply-high, subtract-shift, add and final-shift stages in order.
// Throughput: one item of four lanes per cycle while no recompute runs and results are
// taken; the output stage holds a result while the upstream stages keep filling.
// A divisor write starts a reciprocal recompute, a log2 search followed by the
// one-bit-per-cycle long division; no item is taken while it runs.
// Reset: pipeline empty, divisor one (multiplier 1, both shifts 0).
`default_nettype none
module unsigned32_vector_divide_by_invariant_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  uvdi_cfg_if.sink  cfg_i,
  uvdi_div_if.sink  in_i,
  uvdi_quo_if.source out_o
);

  uvdi_pkg::coef_t coef;
  logic            busy;
  logic            pipe_ready;
  uvdi_pkg::word_t in_data  [uvdi_pkg::LANES];
  uvdi_pkg::word_t out_data [uvdi_pkg::LANES];

  uvdi_recip u_recip (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_ready_o (cfg_i.ready),
    .wr_data_i  (cfg_i.divisor),
    .busy_o     (busy),
    .coef_o     (coef)
  );

  assign in_data[0] = in_i.dividend_0;
  assign in_data[1] = in_i.dividend_1;
  assign in_data[2] = in_i.dividend_2;
  assign in_data[3] = in_i.dividend_3;

  // items wait while the reciprocal is being recomputed
  assign in_i.ready = pipe_ready && !busy;

  uvdi_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coef_i      (coef),
    .in_valid_i  (in_i.valid && !busy),
    .in_ready_o  (pipe_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_data)
  );

  assign out_o.quotient_0 = out_data[0];
  assign out_o.quotient_1 = out_data[1];
  assign out_o.quotient_2 = out_data[2];
  assign out_o.quotient_3 = out_data[3];

endmodule
`default_nettype wire
